/* rtl/plm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

  // Address split: directory index, table index, page offset
  localparam int unsigned DIR_IDX_W         = 10;
  localparam int unsigned TBL_IDX_W         = 10;
  localparam int unsigned OFF_W             = 12;
  localparam int unsigned DIR_ENTRIES       = 1024;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned FRAME_W           = 32 - OFF_W;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_NOT_MAPPED = 2'd3
  } status_e;

  // Input action codes
  typedef enum logic {
    ACT_MAP    = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  // Classification done by the front end
  typedef enum logic [1:0] {
    KIND_MISALIGNED,
    KIND_MAP,
    KIND_LOOKUP
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_DIR,
    BS_TBL
  } back_state_e;

  // Classified command held in the front-end queue
  typedef struct packed {
    kind_e                  kind;
    logic [DIR_IDX_W-1:0]   dir_idx;
    logic [TBL_IDX_W-1:0]   tbl_idx;
    logic [OFF_W-1:0]       offset;
    logic [31:0]            entry;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/plm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface plm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] entry_flags;

  modport source (output valid, action, virt_addr, phys_addr, entry_flags, input ready);
  modport sink   (input valid, action, virt_addr, phys_addr, entry_flags, output ready);
endinterface

`default_nettype wire

/* rtl/plm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface plm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] phys_out;

  modport source (output valid, status, phys_out, input ready);
  modport sink   (input valid, status, phys_out, output ready);
endinterface

`default_nettype wire

/* rtl/plm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_front
  import plm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plm_in_if.sink    in_i,
  input  wire logic clearing_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_pop_i
);

  localparam int unsigned QDEPTH = 2;

  cmd_t       fifo_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  logic       misaligned;
  cmd_t       cmd_new;

  // No transactions taken while the memories are being swept after reset
  assign in_i.ready = (count_q != 2'(QDEPTH)) && !clearing_i;
  assign push       = in_i.valid && in_i.ready;
  assign pop        = cmd_pop_i && (count_q != 2'd0);

  // Classify the incoming transaction
  assign misaligned = (in_i.virt_addr[OFF_W-1:0] != '0) || (in_i.phys_addr[OFF_W-1:0] != '0);

  always_comb begin
    cmd_new.dir_idx = in_i.virt_addr[31 -: DIR_IDX_W];
    cmd_new.tbl_idx = in_i.virt_addr[OFF_W +: TBL_IDX_W];
    cmd_new.offset  = in_i.virt_addr[OFF_W-1:0];
    cmd_new.entry   = {in_i.phys_addr[31:OFF_W], in_i.entry_flags};
    if (action_e'(in_i.action) == ACT_LOOKUP) begin
      cmd_new.kind = KIND_LOOKUP;
    end else if (misaligned) begin
      cmd_new.kind = KIND_MISALIGNED;
    end else begin
      cmd_new.kind = KIND_MAP;
    end
  end

  // Queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o       = fifo_q[rd_ptr_q];
  assign cmd_valid_o = (count_q != 2'd0);

endmodule

`default_nettype wire

/* rtl/plm_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_back
  import plm_pkg::*;
#(
  parameter int unsigned POOL_TABLES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       cmd_pop_o,
  output logic       clearing_o,
  plm_out_if.source  out_o
);

  localparam int unsigned SLOT_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned USED_W    = $clog2(POOL_TABLES + 1);
  localparam int unsigned TBL_DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int unsigned TADDR_W   = $clog2(TBL_DEPTH);
  localparam int unsigned DIR_W     = 1 + SLOT_W;

  back_state_e          state_q, state_d;
  cmd_t                 cur_q;
  logic [USED_W-1:0]    used_q, used_d;
  logic [TADDR_W-1:0]   clr_cnt_q, clr_cnt_d;

  // Directory: present bit over table slot
  logic [DIR_W-1:0]     dir_mem [DIR_ENTRIES];
  logic [DIR_W-1:0]     dir_rd_q;
  logic                 dir_re, dir_we;
  logic [DIR_IDX_W-1:0] dir_waddr;
  logic [DIR_W-1:0]     dir_wdata;

  // Page table pool
  logic [31:0]          tbl_mem [TBL_DEPTH];
  logic [31:0]          tbl_rd_q;
  logic                 tbl_re, tbl_we;
  logic [TADDR_W-1:0]   tbl_addr;
  logic [31:0]          tbl_wdata;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, res_status;
  logic [31:0]          out_phys_q, res_phys;
  logic                 res_load;
  logic                 out_free;

  logic                 dir_present;
  logic [SLOT_W-1:0]    dir_slot;
  logic [SLOT_W-1:0]    new_slot;
  logic [SLOT_W+TBL_IDX_W-1:0] hit_addr_w, new_addr_w;

  assign dir_present = dir_rd_q[DIR_W-1];
  assign dir_slot    = dir_rd_q[SLOT_W-1:0];
  assign new_slot    = used_q[SLOT_W-1:0];
  assign hit_addr_w  = {dir_slot, cur_q.tbl_idx};
  assign new_addr_w  = {new_slot, cur_q.tbl_idx};
  assign out_free    = !out_valid_q || out_o.ready;
  assign clearing_o  = (state_q == BS_CLEAR);

  // Sequencer: directory read, then table read or write
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    clr_cnt_d  = clr_cnt_q;
    cmd_pop_o  = 1'b0;
    dir_re     = 1'b0;
    dir_we     = 1'b0;
    dir_waddr  = cur_q.dir_idx;
    dir_wdata  = {1'b1, new_slot};
    tbl_re     = 1'b0;
    tbl_we     = 1'b0;
    tbl_addr   = hit_addr_w[TADDR_W-1:0];
    tbl_wdata  = cur_q.entry;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_phys   = '0;

    unique case (state_q)
      BS_CLEAR: begin
        // Zero both memories, one entry per cycle
        dir_we    = 1'b1;
        dir_waddr = clr_cnt_q[DIR_IDX_W-1:0];
        dir_wdata = '0;
        tbl_we    = 1'b1;
        tbl_addr  = clr_cnt_q;
        tbl_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == TADDR_W'(TBL_DEPTH - 1)) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            KIND_MISALIGNED: begin
              res_load   = 1'b1;
              res_status = ST_MISALIGNED;
            end
            KIND_MAP, KIND_LOOKUP: begin
              dir_re  = 1'b1;
              state_d = BS_DIR;
            end
            default: begin
              res_load   = 1'b1;
              res_status = ST_MISALIGNED;
            end
          endcase
        end
      end
      BS_DIR: begin
        state_d = BS_IDLE;
        if (cur_q.kind == KIND_LOOKUP) begin
          if (dir_present) begin
            tbl_re  = 1'b1;
            state_d = BS_TBL;
          end else begin
            res_load   = 1'b1;
            res_status = ST_NOT_MAPPED;
          end
        end else begin
          res_load = 1'b1;
          if (dir_present) begin
            tbl_we = 1'b1;
          end else if (used_q >= USED_W'(POOL_TABLES)) begin
            res_status = ST_NO_SPACE;
          end else begin
            // Claim the next pool table
            dir_we   = 1'b1;
            tbl_we   = 1'b1;
            tbl_addr = new_addr_w[TADDR_W-1:0];
            used_d   = used_q + 1'b1;
          end
        end
      end
      BS_TBL: begin
        state_d  = BS_IDLE;
        res_load = 1'b1;
        if (tbl_rd_q[0]) begin
          res_phys = {tbl_rd_q[31:OFF_W], cur_q.offset};
        end else begin
          res_status = ST_NOT_MAPPED;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      used_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_phys_q   <= res_phys;
    end
  end

  // Directory memory
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_rd_q <= dir_mem[cmd_i.dir_idx];
    end
  end

  // Page table memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_addr];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.phys_out = out_phys_q;

endmodule

`default_nettype wire

/* rtl/two_level_page_map_lookup_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-level page map and lookup for 32-bit addresses with 4 KiB pages. Each
// transaction on in_i either maps one page (action 0) or translates one
// address (action 1) and yields exactly one result on out_o. A front end
// classifies transactions into a two-entry queue; a back end walks the
// directory memory and then the page table memory, each a registered read.
// A misaligned map is answered from the back end's idle state, any other map
// takes a directory read, then a table write, and a lookup a directory read,
// then a table read when the directory entry is present, then the result;
// the back end handles one transaction at a time. After reset both memories
// are zeroed by a sweep of POOL_TABLES * 1024 entries, during which in_i is
// not ready. Page tables are taken from the pool in order and never freed.

module two_level_page_map_lookup_top
  import plm_pkg::*;
#(
  parameter int unsigned POOL_TABLES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plm_in_if.sink    in_i,
  plm_out_if.source out_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic clearing;

  plm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .clearing_i  (clearing),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  plm_back #(
    .POOL_TABLES (POOL_TABLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* rtl/plm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module plm_checker
  import plm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_status_i,
  input wire logic [31:0] out_phys_i
);

  logic [3:0] pending_q;
  logic       in_xact;
  logic       out_xact;

  assign in_xact  = in_valid_i && in_ready_i;
  assign out_xact = out_valid_i && out_ready_i;

  // Transactions taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_xact) - 4'(out_xact);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_phys_i))
    else $error("result changed while stalled");

  // Only a successful lookup carries an address
  a_phys_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_phys_i == 32'd0)
    else $error("failed result with nonzero address");

  // No result without an outstanding transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result without a pending transaction");

  // Reset clears the result register
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind two_level_page_map_lookup_top plm_checker u_plm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_phys_i   (out_o.phys_out)
);

`default_nettype wire

/* dv/tb_two_level_page_map_lookup_top.sv */
`timescale 1ns / 1ps

module tb_two_level_page_map_lookup_top
  import plm_pkg::*;
;

  localparam int unsigned POOL         = 16;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ITEMS = 850;
  // limit covers the clearing sweep of POOL * 1024 entries and then every item
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // One map or lookup request as queued for the driver
  typedef struct {
    action_e     act;
    logic [31:0] virt;
    logic [31:0] phys;
    logic [11:0] flags;
    bit          drain;   // hold back until every result is back
  } page_req_t;

  // One expected result
  typedef struct {
    status_e     status;
    logic [31:0] phys;
  } page_res_t;

  logic clk_i;
  logic rst_ni;

  plm_in_if  in_if ();
  plm_out_if out_if ();

  two_level_page_map_lookup_top #(
    .POOL_TABLES(POOL)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow of the page map
  bit          dir_present [DIR_ENTRIES];
  int unsigned dir_slot    [DIR_ENTRIES];
  bit   [31:0] table_mem   [POOL * ENTRIES_PER_TABLE];
  int unsigned tables_used;

  page_req_t pending_reqs[$];
  page_res_t expected_results[$];
  page_req_t cur_req;

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;

  // Apply one request to the shadow map and return the result it yields
  function automatic page_res_t walk_page_map(page_req_t r);
    logic [DIR_IDX_W-1:0] di;
    logic [TBL_IDX_W-1:0] ti;
    logic [31:0]          e;
    page_res_t            res;
    di         = r.virt[31:22];
    ti         = r.virt[21:12];
    res.status = ST_OK;
    res.phys   = '0;
    if (r.act == ACT_MAP) begin
      if (r.virt[OFF_W-1:0] != '0 || r.phys[OFF_W-1:0] != '0) begin
        res.status = ST_MISALIGNED;
      end else if (!dir_present[di] && tables_used >= POOL) begin
        res.status = ST_NO_SPACE;
      end else begin
        if (!dir_present[di]) begin
          dir_slot[di]    = tables_used;
          dir_present[di] = 1'b1;
          tables_used++;
        end
        table_mem[dir_slot[di] * ENTRIES_PER_TABLE + ti] = r.phys | {20'd0, r.flags};
      end
    end else begin
      res.status = ST_NOT_MAPPED;
      if (dir_present[di]) begin
        e = table_mem[dir_slot[di] * ENTRIES_PER_TABLE + ti];
        if (e[0]) begin
          res.status = ST_OK;
          res.phys   = {e[31:OFF_W], r.virt[OFF_W-1:0]};
        end
      end
    end
    return res;
  endfunction

  task automatic queue_req(action_e act, logic [31:0] virt, logic [31:0] phys,
                           logic [11:0] flags, bit drain);
    page_req_t r;
    r.act   = act;
    r.virt  = virt;
    r.phys  = phys;
    r.flags = flags;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] rand_frame();
    logic [31:0] f;
    f            = $urandom;
    f[OFF_W-1:0] = '0;
    return f;
  endfunction

  // Mostly directories that hold (or will hold) a table, now and then any
  function automatic logic [DIR_IDX_W-1:0] pick_dir();
    int unsigned r;
    int unsigned d;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      d = $urandom_range(0, 15);
      return (d == 15) ? 10'd1023 : 10'(d);
    end else if (r < 9) begin
      return 10'($urandom_range(15, 20));
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [TBL_IDX_W-1:0] pick_tbl();
    if ($urandom_range(0, 3) != 0) return 10'($urandom_range(0, 15));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Known values on every input from time zero
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_MAP;
    in_if.virt_addr    = '0;
    in_if.phys_addr    = '0;
    in_if.entry_flags  = '0;
    out_if.ready       = 1'b0;
    err_cnt            = 0;
    cycle_cnt          = 0;
    gap_left           = 0;
    burst_left         = 4;
    stall_mode         = 0;
    stall_left         = 0;
    tables_used        = 0;
    foreach (dir_slot[i]) dir_slot[i] = 0;
  end

  // Request driver: bursts with random gaps, held items wait for the drain
  always @(posedge clk_i) begin : drive_proc
    logic fire;
    logic launch;
    fire   = in_if.valid && in_if.ready;
    launch = 1'b0;
    if (rst_ni) begin
      if (fire) expected_results.push_back(walk_page_map(cur_req));
      if (!in_if.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_results.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          launch  = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
          end
        end
        in_if.valid <= launch;
        if (launch) begin
          in_if.action      <= cur_req.act;
          in_if.virt_addr   <= cur_req.virt;
          in_if.phys_addr   <= cur_req.phys;
          in_if.entry_flags <= cur_req.flags;
        end
      end
    end
  end

  // Result sink back-pressure: modes of varying stall density
  always @(posedge clk_i) begin : stall_proc
    logic rdy;
    rdy = 1'b1;
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (cycle_cnt % 3 == 0);
      endcase
      out_if.ready <= rdy;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : check_proc
    page_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d phys_out %h",
                 $time, out_if.status, out_if.phys_out);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status expected %0d (%s) actual %0d",
                   $time, want.status, want.status.name(), out_if.status);
          err_cnt++;
        end
        if (out_if.phys_out !== want.phys) begin
          $display("%0t: phys_out expected %h actual %h",
                   $time, want.phys, out_if.phys_out);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog_proc
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stim_proc
    int unsigned          r;
    logic [DIR_IDX_W-1:0] d;
    logic [31:0]          va;
    logic [31:0]          pa;
    logic [11:0]          fl;

    // Directed: misses, extremes, misalignment, present bit clear, pool exhaustion
    queue_req(ACT_LOOKUP, 32'h0000_0000, 32'h0, 12'h0, 1'b0);
    queue_req(ACT_MAP,    32'h0000_0000, 32'hFFFF_F000, 12'hFFF, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h0, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_1000, 32'h0, 12'h0, 1'b0);
    queue_req(ACT_MAP,    32'h0000_0801, 32'h0, 12'h001, 1'b0);
    queue_req(ACT_MAP,    32'h0040_0000, 32'h0000_0FFF, 12'h001, 1'b0);
    queue_req(ACT_MAP,    32'hFFFF_F000, 32'h1234_5000, 12'hFFE, 1'b0);
    queue_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b0);
    // claim the remaining tables, then one more directory than the pool holds
    for (int i = 1; i <= 14; i++) begin
      queue_req(ACT_MAP, {10'(i), 10'(i), 12'h0}, rand_frame(),
                {11'($urandom_range(0, 2047)), 1'b1}, 1'b0);
    end
    queue_req(ACT_MAP,    {10'd15, 10'd0, 12'h0}, rand_frame(), 12'h001, 1'b0);
    queue_req(ACT_LOOKUP, {10'd15, 10'd0, 12'h0}, 32'h0, 12'h0, 1'b1);
    queue_req(ACT_LOOKUP, {10'd14, 10'd14, 12'hABC}, 32'h0, 12'h0, 1'b0);

    // Random: mostly well-formed maps and lookups over a small working set
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      d = pick_dir();
      if (r < 45) begin
        va = {d, pick_tbl(), 12'h0};
        pa = rand_frame();
        fl = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) != 0) fl[0] = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) va[$urandom_range(0, 11)] = 1'b1;
          else pa[$urandom_range(0, 11)] = 1'b1;
        end
        queue_req(ACT_MAP, va, pa, fl, (i % 200) == 100);
      end else if (r < 85) begin
        queue_req(ACT_LOOKUP, {d, pick_tbl(), 12'($urandom_range(0, 4095))},
                  $urandom, 12'($urandom_range(0, 4095)), (i % 200) == 100);
      end else begin
        queue_req(action_e'($urandom_range(0, 1)), $urandom, $urandom,
                  12'($urandom_range(0, 4095)), (i % 200) == 100);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_if.valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/plm_pkg.sv
rtl/plm_in_if.sv
rtl/plm_out_if.sv
rtl/plm_front.sv
rtl/plm_back.sv
rtl/two_level_page_map_lookup_top.sv
rtl/plm_checker.sv
dv/tb_two_level_page_map_lookup_top.sv
